@@ src/ile_pkg.sv @@
// Shared types and codes for the indexed list engine.
// Holds the request codes, status codes and the plan record passed from the
// request checker to the sequencer. No dependencies.
`default_nettype none

package ile_pkg;

    // Request codes carried on the op port.
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_APPEND     = 3'd1;
    localparam logic [2:0] OP_INSERT     = 3'd2;
    localparam logic [2:0] OP_DELETE     = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;
    localparam logic [2:0] OP_CLEAR      = 3'd5;

    // Status codes returned with every result.
    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Width of the entry_count port.
    localparam int COUNT_PORT_W = 5;

    // What the sequencer has to do for one request.
    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_INSERT = 3'd1,
        K_DELETE = 3'd2,
        K_READ   = 3'd3,
        K_CLEAR  = 3'd4
    } kind_t;

    // Plan record from the request checker.
    typedef struct packed {
        kind_t      kind;
        logic [1:0] status;
    } plan_t;

endpackage

`default_nettype wire

@@ src/ile_plan.sv @@
// Request checker for the indexed list engine.
// Decodes op, checks capacity and index range, and picks the target index.
// Depends on ile_pkg.
`default_nettype none

module ile_plan #(
    parameter int CAPACITY = 16
) (
    input  wire logic [2:0]                      op,
    input  wire logic [3:0]                      position,
    input  wire logic [$clog2(CAPACITY+1)-1:0]   count,
    output ile_pkg::plan_t                       plan,
    output logic [$clog2(CAPACITY+1)-1:0]        target
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic            full;
    logic            pos_in_list;
    logic            pos_at_most_cnt;

    // Compare position and count at a common width.
    assign pos_ext         = CMPW'(position);
    assign cnt_ext         = CMPW'(count);
    assign full            = (cnt_ext >= CMPW'(CAPACITY));
    assign pos_in_list     = (pos_ext < cnt_ext);
    assign pos_at_most_cnt = (pos_ext <= cnt_ext);

    // Decode the request into a plan; failed requests do nothing.
    always_comb
    begin
        plan.kind   = ile_pkg::K_NONE;
        plan.status = ile_pkg::ST_DONE;
        target      = '0;
        case (op)
            ile_pkg::OP_PUSH_FRONT:
            begin
                if (full)
                    plan.status = ile_pkg::ST_FULL;
                else
                    plan.kind = ile_pkg::K_INSERT;
            end
            ile_pkg::OP_APPEND:
            begin
                target = count;
                if (full)
                    plan.status = ile_pkg::ST_FULL;
                else
                    plan.kind = ile_pkg::K_INSERT;
            end
            ile_pkg::OP_INSERT:
            begin
                target = CW'(pos_ext);
                if (full)
                    plan.status = ile_pkg::ST_FULL;
                else if (!pos_at_most_cnt)
                    plan.status = ile_pkg::ST_RANGE;
                else
                    plan.kind = ile_pkg::K_INSERT;
            end
            ile_pkg::OP_DELETE:
            begin
                target = CW'(pos_ext);
                if (pos_in_list)
                    plan.kind = ile_pkg::K_DELETE;
                else
                    plan.status = ile_pkg::ST_RANGE;
            end
            ile_pkg::OP_READ:
            begin
                target = CW'(pos_ext);
                if (pos_in_list)
                    plan.kind = ile_pkg::K_READ;
                else
                    plan.status = ile_pkg::ST_RANGE;
            end
            ile_pkg::OP_CLEAR:
            begin
                if (count == '0)
                    plan.status = ile_pkg::ST_RANGE;
                else
                    plan.kind = ile_pkg::K_CLEAR;
            end
            default:
            begin
                plan.kind   = ile_pkg::K_NONE;
                plan.status = ile_pkg::ST_DONE;
            end
        endcase
    end

endmodule

`default_nettype wire

@@ src/indexed_list_engine.sv @@
// Top level of the indexed list engine: sequencer, entry memory and count.
// Depends on ile_pkg and ile_plan.
`default_nettype none

// Usage
// A request is a transfer on start/busy: it is taken at a rising edge with
// start high and busy low. busy stays high until the result has been shown.
// Each request gives one result: result_value, entry_count and status are
// valid for exactly one cycle while done is high; the receiver cannot stall.
// The entries live in a memory with one read and one write port, and insert
// and delete move them one at a time, so latency depends on how far they move.
// Insert (push, append, insert) moves each entry from the tail down to the
// target index up one place through the step, read and write states, then
// writes the value in a last step; delete reads each entry from the index to
// the tail, keeps the first as the result and writes the others one place
// down; read passes through read and write. Clear, failed requests and unused codes go straight to the done state.
// A new request may be taken in the cycle after done.
// Reset empties the list (count zero) and returns the sequencer to idle; the
// memory contents are not cleared, since only written entries are ever read.

module indexed_list_engine #(
    parameter int CAPACITY = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [2:0]         op,
    input  wire logic [3:0]         position,
    input  wire logic signed [31:0] item_value,
    output logic                    done,
    output logic signed [31:0]      result_value,
    output logic [4:0]              entry_count,
    output logic [1:0]              status
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_STEP  = 5'b00010,
        S_READ  = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t          state_reg, state_next;
    ile_pkg::kind_t  kind_reg, kind_next;
    logic [1:0]      status_reg, status_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   target_reg, target_next;
    logic            first_reg, first_next;
    logic [31:0]     value_reg, value_next;
    logic [31:0]     result_reg, result_next;
    logic [31:0]     rdata_reg;

    ile_pkg::plan_t  plan;
    logic [CW-1:0]   plan_target;

    logic [31:0]     mem [CAPACITY];
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic [31:0]     wr_data;
    logic [CW-1:0]   idx_inc;
    logic [CW-1:0]   idx_dec;

    // Request checker.
    ile_plan #(
        .CAPACITY (CAPACITY)
    ) u_plan (
        .op       (op),
        .position (position),
        .count    (count_reg),
        .plan     (plan),
        .target   (plan_target)
    );

    assign idx_inc = idx_reg + CW'(1);
    assign idx_dec = idx_reg - CW'(1);

    // Insert reads the entry below the hole; delete and read read at idx.
    assign rd_addr = (kind_reg == ile_pkg::K_INSERT) ? idx_dec[AW-1:0] : idx_reg[AW-1:0];

    // Sequencer next-state and memory write control.
    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        target_next = target_reg;
        first_next  = first_reg;
        value_next  = value_reg;
        result_next = result_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg[AW-1:0];
        wr_data     = rdata_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next   = plan.kind;
                    status_next = plan.status;
                    target_next = plan_target;
                    value_next  = item_value;
                    result_next = '0;
                    first_next  = 1'b1;
                    case (plan.kind)
                        ile_pkg::K_INSERT:
                        begin
                            idx_next   = count_reg;
                            state_next = S_STEP;
                        end
                        ile_pkg::K_DELETE, ile_pkg::K_READ:
                        begin
                            idx_next   = plan_target;
                            state_next = S_READ;
                        end
                        ile_pkg::K_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_STEP:
            begin
                // Open the hole one entry at a time, then drop the value in.
                if (idx_reg > target_reg)
                begin
                    state_next = S_READ;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = idx_reg[AW-1:0];
                    wr_data    = value_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_DONE;
                end
            end
            S_READ:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                case (kind_reg)
                    ile_pkg::K_INSERT:
                    begin
                        wr_en      = 1'b1;
                        wr_addr    = idx_reg[AW-1:0];
                        idx_next   = idx_dec;
                        state_next = S_STEP;
                    end
                    ile_pkg::K_DELETE:
                    begin
                        // First pass captures the removed value, later ones close the gap.
                        if (first_reg)
                        begin
                            result_next = rdata_reg;
                            first_next  = 1'b0;
                        end
                        else
                        begin
                            wr_en   = 1'b1;
                            wr_addr = idx_dec[AW-1:0];
                        end
                        idx_next = idx_inc;
                        if (idx_inc < count_reg)
                        begin
                            state_next = S_READ;
                        end
                        else
                        begin
                            count_next = count_reg - CW'(1);
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        result_next = rdata_reg;
                        state_next  = S_DONE;
                    end
                endcase
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= ile_pkg::K_NONE;
            count_reg <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
            count_reg <= count_next;
            first_reg <= first_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        idx_reg    <= idx_next;
        target_reg <= target_next;
        value_reg  <= value_next;
        result_reg <= result_next;
    end

    // Entry memory: one read and one write per cycle, read data registered.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_READ)
            rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
    end

    // Result ports.
    assign busy         = (state_reg != S_IDLE);
    assign done         = (state_reg == S_DONE);
    assign result_value = result_reg;
    assign entry_count  = ile_pkg::COUNT_PORT_W'(count_reg);
    assign status       = status_reg;

`ifndef SYNTHESIS
    // A taken request always makes the engine busy.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("request taken but engine not busy");

    // The engine is free again right after a result.
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !busy)
        else $error("engine still busy after result");

    // The list never grows past its capacity.
    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= CW'(CAPACITY))
        else $error("entry count above capacity");

    // A failed request returns no value and leaves the count alone.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ile_pkg::ST_DONE) |-> (result_value == '0 && $stable(count_reg)))
        else $error("failed request changed state or returned a value");
`endif

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for indexed_list_engine.
// Holds a behavioral list predictor, a request driver, a result checker and a
// watchdog. Depends on ile_pkg and the indexed_list_engine RTL.
`timescale 1ns / 100ps

module testbench;

    // Codes the block is expected to ignore.
    localparam logic [2:0] OP_RESERVED_A = 3'd6;
    localparam logic [2:0] OP_RESERVED_B = 3'd7;

    localparam int LIST_CAP       = 16;
    localparam int IDLE_LIMIT     = 2000;
    localparam int SETTLE_CYCLES  = 60;

    // One expected result of a request.
    typedef struct {
        logic signed [31:0] value;
        logic [4:0]         count;
        logic [1:0]         status;
    } list_result_t;

    logic               clk;
    logic               rst_n      = 1'b0;
    logic               start      = 1'b0;
    logic [2:0]         op         = ile_pkg::OP_PUSH_FRONT;
    logic [3:0]         position   = '0;
    logic signed [31:0] item_value = '0;
    logic               busy;
    logic               done;
    logic signed [31:0] result_value;
    logic [4:0]         entry_count;
    logic [1:0]         status;

    // Predictor state: the list contents and its length.
    logic signed [31:0] list_mem [LIST_CAP];
    int                 list_count = 0;

    list_result_t       pending_results [$];
    int                 error_count = 0;
    int                 idle_cycles = 0;

    indexed_list_engine #(
        .CAPACITY(LIST_CAP)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .op(op),
        .position(position),
        .item_value(item_value),
        .done(done),
        .result_value(result_value),
        .entry_count(entry_count),
        .status(status)
    );

    // Free-running 2 ns clock.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Store a value at an index, shifting the later entries toward the tail.
    function automatic logic [1:0] place_entry(input int idx, input logic signed [31:0] val);
        int k;
        if (list_count >= LIST_CAP)
            return ile_pkg::ST_FULL;
        if (idx > list_count)
            return ile_pkg::ST_RANGE;
        for (k = list_count; k > idx; k--)
            list_mem[k] = list_mem[k - 1];
        list_mem[idx] = val;
        list_count++;
        return ile_pkg::ST_DONE;
    endfunction

    // Apply one request to the predicted list and return its result.
    function automatic list_result_t apply_request(input logic [2:0] req_op,
                                                   input logic [3:0] req_pos,
                                                   input logic signed [31:0] req_val);
        list_result_t r;
        int           k;
        int           pos;
        pos      = int'(req_pos);
        r.value  = '0;
        r.status = ile_pkg::ST_DONE;
        case (req_op)
            ile_pkg::OP_PUSH_FRONT: r.status = place_entry(0, req_val);
            ile_pkg::OP_APPEND:     r.status = place_entry(list_count, req_val);
            ile_pkg::OP_INSERT:     r.status = place_entry(pos, req_val);
            ile_pkg::OP_DELETE:
            begin
                if (pos < list_count)
                begin
                    r.value = list_mem[pos];
                    for (k = pos; k < list_count - 1; k++)
                        list_mem[k] = list_mem[k + 1];
                    list_count--;
                end
                else
                    r.status = ile_pkg::ST_RANGE;
            end
            ile_pkg::OP_READ:
            begin
                if (pos < list_count)
                    r.value = list_mem[pos];
                else
                    r.status = ile_pkg::ST_RANGE;
            end
            ile_pkg::OP_CLEAR:
            begin
                if (list_count == 0)
                    r.status = ile_pkg::ST_RANGE;
                else
                    list_count = 0;
            end
            default: ;
        endcase
        r.count = 5'(list_count);
        return r;
    endfunction

    // Idle gap before a request: mostly short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(10, 4);
        return $urandom_range(40, 20);
    endfunction

    // Drive one request and wait for its transfer; start is left high so that
    // a following request can go out back to back.
    task automatic send_request(input logic [2:0] req_op, input logic [3:0] req_pos,
                                input logic signed [31:0] req_val, input int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start      <= 1'b1;
        op         <= req_op;
        position   <= req_pos;
        item_value <= req_val;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_results.push_back(apply_request(req_op, req_pos, req_val));
    endtask

    // Random request. grow_pct sets how often an entry is added, which steers
    // the list toward full or toward empty.
    task automatic send_random_item(input int grow_pct, input bit no_gaps);
        logic [2:0]         req_op;
        logic [3:0]         req_pos;
        logic signed [31:0] req_val;
        int                 r;
        r = $urandom_range(99);
        if (r < 2)
            req_op = ($urandom_range(1) == 0) ? OP_RESERVED_A : OP_RESERVED_B;
        else if (r < 5)
            req_op = ile_pkg::OP_CLEAR;
        else if (r < 5 + grow_pct)
        begin
            case ($urandom_range(2))
                0:       req_op = ile_pkg::OP_PUSH_FRONT;
                1:       req_op = ile_pkg::OP_APPEND;
                default: req_op = ile_pkg::OP_INSERT;
            endcase
        end
        else if (r < 20 + grow_pct)
            req_op = ile_pkg::OP_READ;
        else
            req_op = ile_pkg::OP_DELETE;

        // Mostly legal indices, with some arbitrary ones as noise.
        if ($urandom_range(9) == 0)
            req_pos = 4'($urandom_range(15));
        else if (req_op == ile_pkg::OP_INSERT)
            req_pos = 4'($urandom_range((list_count > 15) ? 15 : list_count, 0));
        else if (list_count == 0)
            req_pos = 4'($urandom_range(15));
        else
            req_pos = 4'($urandom_range(list_count - 1, 0));

        case ($urandom_range(7))
            0:       req_val = 32'sh8000_0000;
            1:       req_val = 32'sh7fff_ffff;
            2:       req_val = '0;
            3:       req_val = -32'sd1;
            default: req_val = $urandom;
        endcase

        send_request(req_op, req_pos, req_val, no_gaps ? 0 : pick_gap());
    endtask

    // Requests on an empty list, append to empty, delete at head, ignored codes.
    task automatic test_empty_list();
        send_request(ile_pkg::OP_READ, 4'd0, '0, pick_gap());
        send_request(ile_pkg::OP_DELETE, 4'd0, '0, pick_gap());
        send_request(ile_pkg::OP_CLEAR, 4'd15, '0, pick_gap());
        send_request(ile_pkg::OP_INSERT, 4'd1, 32'sd5, pick_gap());
        send_request(ile_pkg::OP_APPEND, 4'd9, 32'sh1234_5678, pick_gap());
        send_request(ile_pkg::OP_DELETE, 4'd0, '0, pick_gap());
        send_request(OP_RESERVED_A, 4'd15, -32'sd1, pick_gap());
        send_request(OP_RESERVED_B, 4'd0, 32'sh7fff_ffff, pick_gap());
    endtask

    // Fill the list, starting with extreme values, then try to add to a full list, read both ends and clear it.
    task automatic test_fill_to_capacity();
        send_request(ile_pkg::OP_APPEND, 4'd0, 32'sh7fff_ffff, pick_gap());
        send_request(ile_pkg::OP_PUSH_FRONT, 4'd0, 32'sh8000_0000, pick_gap());
        send_request(ile_pkg::OP_INSERT, 4'd1, -32'sd1, pick_gap());
        send_request(ile_pkg::OP_INSERT, 4'd3, '0, pick_gap());
        for (int k = 4; k < LIST_CAP; k++)
        begin
            case (k % 3)
                0:       send_request(ile_pkg::OP_INSERT, 4'(k), $urandom, pick_gap());
                1:       send_request(ile_pkg::OP_APPEND, 4'(k), $urandom, pick_gap());
                default: send_request(ile_pkg::OP_PUSH_FRONT, 4'(k), $urandom, pick_gap());
            endcase
        end
        send_request(ile_pkg::OP_PUSH_FRONT, 4'd0, 32'sd1, pick_gap());
        send_request(ile_pkg::OP_APPEND, 4'd0, 32'sd2, pick_gap());
        send_request(ile_pkg::OP_INSERT, 4'd7, 32'sd3, pick_gap());
        send_request(ile_pkg::OP_READ, 4'd15, '0, pick_gap());
        send_request(ile_pkg::OP_READ, 4'd0, '0, pick_gap());
        send_request(ile_pkg::OP_CLEAR, 4'd0, '0, pick_gap());
    endtask

    // Random traffic biased toward a filling list.
    task automatic test_growing_list();
        repeat (300) send_random_item(60, 1'b0);
    endtask

    // Random traffic biased toward a draining list.
    task automatic test_shrinking_list();
        repeat (300) send_random_item(25, 1'b0);
    endtask

    // Balanced random traffic.
    task automatic test_mixed_traffic();
        repeat (500) send_random_item(45, 1'b0);
    endtask

    // Requests issued as fast as the block takes them.
    task automatic test_back_to_back();
        repeat (150) send_random_item(48, 1'b1);
    endtask

    // Main sequence: reset, tests in turn, then drain and report.
    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_fill_to_capacity();
        test_growing_list();
        test_shrinking_list();
        test_mixed_traffic();
        test_back_to_back();

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("PASS indexed_list_engine");
        else
            $display("FAIL indexed_list_engine");
        $finish;
    end

    // Compare each result with the oldest expectation.
    always @(posedge clk)
    begin
        list_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: value %0d, count %0d, status %0d",
                       result_value, entry_count, status);
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (result_value !== exp_r.value)
                begin
                    $error("result_value mismatch: expected %0d, actual %0d",
                           exp_r.value, result_value);
                    error_count++;
                end
                if (entry_count !== exp_r.count)
                begin
                    $error("entry_count mismatch: expected %0d, actual %0d",
                           exp_r.count, entry_count);
                    error_count++;
                end
                if (status !== exp_r.status)
                begin
                    $error("status mismatch: expected %0d, actual %0d",
                           exp_r.status, status);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no transfer happens for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL indexed_list_engine");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
